@@ rtl/core/reliable_datagram_tracker_macros.svh @@
// assertion macros for the datagram tracker
`ifndef RELIABLE_DATAGRAM_TRACKER_MACROS_SVH
`define RELIABLE_DATAGRAM_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define RDT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define RDT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RDT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RDT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/rdt_pkg.sv @@
package rdt_pkg;

    localparam int OP_W      = 2;
    localparam int PEER_W    = 48;
    localparam int SEQ_W     = 32;
    localparam int TMR_W     = 20;
    localparam int EV_W      = 4;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 4;

    localparam int OUT_ENTRIES_DEF = 16;
    localparam int IN_ENTRIES_DEF  = 32;

    localparam logic [TMR_W-1:0] RETX_RST = 20'd100;
    localparam logic [TMR_W-1:0] RSV_RST  = 20'd60000;

    localparam logic [CFG_IDX_W-1:0] CFG_RETX = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV  = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_SEND = 2'd0,
        OP_DATA = 2'd1,
        OP_ACK  = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef enum logic [EV_W-1:0] {
        EV_ADDED     = 4'd0,
        EV_REPLACED  = 4'd1,
        EV_OUT_FULL  = 4'd2,
        EV_NEW       = 4'd3,
        EV_DUP       = 4'd4,
        EV_NEW_NOREC = 4'd5,
        EV_ACKED     = 4'd6,
        EV_UNK_ACK   = 4'd7,
        EV_RESEND    = 4'd8,
        EV_IDLE_TICK = 4'd9
    } t_ev;

    typedef struct packed {
        logic              v;
        logic [PEER_W-1:0] peer;
        logic [SEQ_W-1:0]  seq;
        logic [TMR_W-1:0]  tmr;
    } t_ent;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [PEER_W-1:0] peer;
        logic [SEQ_W-1:0]  seq;
        logic [SLOT_W-1:0] slot;
        logic              ack;
        logic              dlv;
        logic              last;
    } t_res;

    typedef struct packed {
        logic take;
        logic idx_zero;
        logic idx_inc;
        logic clr;
        logic all;
        logic rd;
        logic tin;
        logic lk_eval;
        logic act;
        logic tick_wb;
        logic tev;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic            last;
        logic [OP_W-1:0] op;
        logic            expire;
        logic            pend;
        logic            out_free;
    } t_sts;

endpackage

@@ rtl/core/rdt_in_if.sv @@
interface rdt_in_if;
    logic                        valid;
    logic                        ready;
    logic [rdt_pkg::OP_W-1:0]    op;
    logic [rdt_pkg::PEER_W-1:0]  peer_addr;
    logic [rdt_pkg::SEQ_W-1:0]   seq_num;

    modport source (output valid, op, peer_addr, seq_num, input ready);
    modport sink (input valid, op, peer_addr, seq_num, output ready);
endinterface

@@ rtl/core/rdt_out_if.sv @@
interface rdt_out_if;
    logic                        valid;
    logic                        ready;
    logic [rdt_pkg::EV_W-1:0]    event_res;
    logic [rdt_pkg::PEER_W-1:0]  out_peer;
    logic [rdt_pkg::SEQ_W-1:0]   out_seq;
    logic [rdt_pkg::SLOT_W-1:0]  slot;
    logic                        send_ack;
    logic                        deliver;
    logic                        last;

    modport source (output valid, event_res, out_peer, out_seq, slot, send_ack, deliver, last,
                    input ready);
    modport sink (input valid, event_res, out_peer, out_seq, slot, send_ack, deliver, last,
                  output ready);
endinterface

@@ rtl/core/rdt_cfg_if.sv @@
interface rdt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rdt_pkg::CFG_IDX_W-1:0] index;
    logic [rdt_pkg::TMR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rdt_ctrl.sv @@
`include "reliable_datagram_tracker_macros.svh"

module rdt_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [rdt_pkg::OP_W-1:0] i_in_op,
    input  rdt_pkg::t_sts            i_sts,
    output rdt_pkg::t_cmd            o_cmd,
    output logic                     o_in_ready
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LOOK,
        S_LOOK_END,
        S_ACT,
        S_TIN,
        S_TIN_END,
        S_TOUT_RD,
        S_TOUT_EV,
        S_TFIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   lk_in;

    assign lk_in      = (i_sts.op == rdt_pkg::OP_DATA);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                o_cmd.all = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take     = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    n_state = (i_in_op == rdt_pkg::OP_TICK) ? S_TIN : S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.rd      = 1'b1;
                o_cmd.tin     = lk_in;
                o_cmd.lk_eval = 1'b1;
                if (i_sts.last) begin
                    n_state = S_LOOK_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LOOK_END: begin
                o_cmd.tin     = lk_in;
                o_cmd.lk_eval = 1'b1;
                n_state       = S_ACT;
            end
            S_ACT: begin
                if (i_sts.out_free) begin
                    o_cmd.act = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_TIN: begin
                o_cmd.rd      = 1'b1;
                o_cmd.tin     = 1'b1;
                o_cmd.tick_wb = 1'b1;
                if (i_sts.last) begin
                    n_state = S_TIN_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_TIN_END: begin
                o_cmd.tick_wb  = 1'b1;
                o_cmd.idx_zero = 1'b1;
                n_state        = S_TOUT_RD;
            end
            S_TOUT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TOUT_EV;
            end
            S_TOUT_EV: begin
                if (!(i_sts.expire && i_sts.pend && !i_sts.out_free)) begin
                    o_cmd.tev = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_TFIN;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_TOUT_RD;
                    end
                end
            end
            S_TFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    `RDT_ASSERT_IMP(a_act_free, i_clk, i_rst_n, o_cmd.act, i_sts.out_free)
    `RDT_ASSERT_IMP(a_fin_free, i_clk, i_rst_n, o_cmd.fin, i_sts.out_free)
    `RDT_ASSERT_IMP(a_resend_free, i_clk, i_rst_n, o_cmd.tev && i_sts.expire && i_sts.pend, i_sts.out_free)
    `RDT_ASSERT_NXT(a_clr_done, i_clk, i_rst_n, r_state == S_CLR && i_sts.last, r_state == S_IDLE)

endmodule

@@ rtl/core/rdt_dp.sv @@
module rdt_dp #(
    parameter int OUT_ENTRIES = rdt_pkg::OUT_ENTRIES_DEF,
    parameter int IN_ENTRIES  = rdt_pkg::IN_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rdt_pkg::t_cmd                 i_cmd,
    output rdt_pkg::t_sts                 o_sts,
    input  logic [rdt_pkg::OP_W-1:0]      i_in_op,
    input  logic [rdt_pkg::PEER_W-1:0]    i_in_peer,
    input  logic [rdt_pkg::SEQ_W-1:0]     i_in_seq,
    input  logic                          i_cfg_valid,
    input  logic [rdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rdt_pkg::TMR_W-1:0]     i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rdt_pkg::t_res                 o_res
);

    localparam int MAXN = (OUT_ENTRIES > IN_ENTRIES) ? OUT_ENTRIES : IN_ENTRIES;
    localparam int IXW  = $clog2(MAXN);
    localparam int OW   = $clog2(OUT_ENTRIES);
    localparam int IW   = $clog2(IN_ENTRIES);

    rdt_pkg::t_ent r_omem [OUT_ENTRIES];
    rdt_pkg::t_ent r_imem [IN_ENTRIES];

    logic [rdt_pkg::TMR_W-1:0]  r_retx;
    logic [rdt_pkg::TMR_W-1:0]  r_rsv;
    logic [rdt_pkg::OP_W-1:0]   r_op;
    logic [rdt_pkg::PEER_W-1:0] r_peer;
    logic [rdt_pkg::SEQ_W-1:0]  r_seq;
    logic [IXW-1:0]             r_idx;
    logic [IXW-1:0]             r_ridx;
    logic                       r_rv;
    rdt_pkg::t_ent              r_ordat;
    rdt_pkg::t_ent              r_irdat;
    logic                       r_hit;
    logic [IXW-1:0]             r_hidx;
    logic                       r_free;
    logic [IXW-1:0]             r_fidx;
    logic                       r_pend;
    logic [IXW-1:0]             r_pidx;
    logic [rdt_pkg::PEER_W-1:0] r_ppeer;
    logic [rdt_pkg::SEQ_W-1:0]  r_pseq;
    logic                       r_ovalid;
    rdt_pkg::t_res              r_res;

    rdt_pkg::t_ent              ent_l;
    logic                       match;
    logic [rdt_pkg::TMR_W-1:0]  dec_i;
    logic [rdt_pkg::TMR_W-1:0]  dec_o;
    logic                       expire;
    logic                       out_free;
    logic                       o_we;
    logic [OW-1:0]              o_wa;
    rdt_pkg::t_ent              o_wd;
    logic                       i_we;
    logic [IW-1:0]              i_wa;
    rdt_pkg::t_ent              i_wd;
    logic                       push;
    rdt_pkg::t_res              n_res;
    logic                       clr_o;
    logic                       clr_i;

    assign ent_l = (r_op == rdt_pkg::OP_DATA) ? r_irdat : r_ordat;
    assign match = ent_l.v && (ent_l.peer == r_peer) && (ent_l.seq == r_seq);
    assign dec_i = (r_irdat.tmr == '0) ? '0 : r_irdat.tmr - 1'b1;
    assign dec_o = (r_ordat.tmr == '0) ? '0 : r_ordat.tmr - 1'b1;
    assign expire   = r_ordat.v && (dec_o == '0);
    assign out_free = !r_ovalid || i_out_ready;
    assign clr_o = ({1'b0, r_idx} < (IXW+1)'(OUT_ENTRIES));
    assign clr_i = ({1'b0, r_idx} < (IXW+1)'(IN_ENTRIES));

    always_comb begin
        o_sts.op       = r_op;
        o_sts.expire   = expire;
        o_sts.pend     = r_pend;
        o_sts.out_free = out_free;
        if (i_cmd.all) begin
            o_sts.last = (r_idx == IXW'(MAXN - 1));
        end else if (i_cmd.tin) begin
            o_sts.last = (r_idx == IXW'(IN_ENTRIES - 1));
        end else begin
            o_sts.last = (r_idx == IXW'(OUT_ENTRIES - 1));
        end
    end

    // outgoing table write port
    always_comb begin
        o_we = 1'b0;
        o_wa = r_idx[OW-1:0];
        o_wd = '0;
        priority if (i_cmd.clr) begin
            o_we = clr_o;
        end else if (i_cmd.act && r_op == rdt_pkg::OP_SEND && (r_hit || r_free)) begin
            o_we = 1'b1;
            o_wa = r_hit ? r_hidx[OW-1:0] : r_fidx[OW-1:0];
            o_wd = {1'b1, r_peer, r_seq, r_retx};
        end else if (i_cmd.act && r_op == rdt_pkg::OP_ACK && r_hit) begin
            o_we = 1'b1;
            o_wa = r_hidx[OW-1:0];
            o_wd = {1'b0, r_peer, r_seq, r_retx};
        end else if (i_cmd.tev) begin
            o_we = 1'b1;
            o_wa = r_ridx[OW-1:0];
            o_wd = r_ordat;
            if (expire) begin
                o_wd.tmr = r_retx;
            end else if (r_ordat.v) begin
                o_wd.tmr = dec_o;
            end
        end else begin
            o_we = 1'b0;
        end
    end

    // incoming table write port
    always_comb begin
        i_we = 1'b0;
        i_wa = r_idx[IW-1:0];
        i_wd = '0;
        priority if (i_cmd.clr) begin
            i_we = clr_i;
        end else if (i_cmd.act && r_op == rdt_pkg::OP_DATA && !r_hit && r_free) begin
            i_we = 1'b1;
            i_wa = r_fidx[IW-1:0];
            i_wd = {1'b1, r_peer, r_seq, r_rsv};
        end else if (i_cmd.tick_wb && r_rv) begin
            i_we = 1'b1;
            i_wa = r_ridx[IW-1:0];
            i_wd = r_irdat;
            if (r_irdat.v) begin
                i_wd.tmr = dec_i;
                i_wd.v   = (dec_i != '0);
            end
        end else begin
            i_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_omem[o_wa] <= o_wd;
        end
        if (i_cmd.rd && !i_cmd.tin) begin
            r_ordat <= r_omem[r_idx[OW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_imem[i_wa] <= i_wd;
        end
        if (i_cmd.rd && i_cmd.tin) begin
            r_irdat <= r_imem[r_idx[IW-1:0]];
        end
    end

    // result selection
    always_comb begin
        push  = 1'b0;
        n_res = '0;
        n_res.peer = r_peer;
        n_res.seq  = r_seq;
        n_res.last = 1'b1;
        if (i_cmd.act) begin
            push = 1'b1;
            unique case (r_op)
                rdt_pkg::OP_SEND: begin
                    if (r_hit) begin
                        n_res.ev   = rdt_pkg::EV_REPLACED;
                        n_res.slot = rdt_pkg::SLOT_W'(r_hidx);
                    end else if (r_free) begin
                        n_res.ev   = rdt_pkg::EV_ADDED;
                        n_res.slot = rdt_pkg::SLOT_W'(r_fidx);
                    end else begin
                        n_res.ev   = rdt_pkg::EV_OUT_FULL;
                    end
                end
                rdt_pkg::OP_DATA: begin
                    n_res.ack = 1'b1;
                    if (r_hit) begin
                        n_res.ev   = rdt_pkg::EV_DUP;
                        n_res.slot = rdt_pkg::SLOT_W'(r_hidx);
                    end else if (r_free) begin
                        n_res.ev   = rdt_pkg::EV_NEW;
                        n_res.slot = rdt_pkg::SLOT_W'(r_fidx);
                        n_res.dlv  = 1'b1;
                    end else begin
                        n_res.ev   = rdt_pkg::EV_NEW_NOREC;
                        n_res.dlv  = 1'b1;
                    end
                end
                rdt_pkg::OP_ACK: begin
                    if (r_hit) begin
                        n_res.ev   = rdt_pkg::EV_ACKED;
                        n_res.slot = rdt_pkg::SLOT_W'(r_hidx);
                    end else begin
                        n_res.ev   = rdt_pkg::EV_UNK_ACK;
                    end
                end
                default: begin
                    n_res.ev = rdt_pkg::EV_IDLE_TICK;
                end
            endcase
        end else if ((i_cmd.tev && expire && r_pend) || i_cmd.fin) begin
            push = 1'b1;
            if (r_pend) begin
                n_res.ev   = rdt_pkg::EV_RESEND;
                n_res.peer = r_ppeer;
                n_res.seq  = r_pseq;
                n_res.slot = rdt_pkg::SLOT_W'(r_pidx);
                n_res.last = i_cmd.fin;
            end else begin
                n_res.ev   = rdt_pkg::EV_IDLE_TICK;
                n_res.peer = '0;
                n_res.seq  = '0;
            end
        end else begin
            push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retx   <= rdt_pkg::RETX_RST;
            r_rsv    <= rdt_pkg::RSV_RST;
            r_idx    <= '0;
            r_rv     <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == rdt_pkg::CFG_RETX) begin
                r_retx <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == rdt_pkg::CFG_RSV) begin
                r_rsv <= i_cfg_data;
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rv <= i_cmd.rd;
            if (i_cmd.take) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (i_cmd.lk_eval && r_rv) begin
                if (match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!ent_l.v && !r_free) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.take || i_cmd.fin) begin
                r_pend <= 1'b0;
            end else if (i_cmd.tev && expire) begin
                r_pend <= 1'b1;
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= i_in_op;
            r_peer <= i_in_peer;
            r_seq  <= i_in_seq;
        end
        if (i_cmd.rd) begin
            r_ridx <= r_idx;
        end
        if (i_cmd.lk_eval && r_rv && match && !r_hit) begin
            r_hidx <= r_ridx;
        end
        if (i_cmd.lk_eval && r_rv && !ent_l.v && !r_free) begin
            r_fidx <= r_ridx;
        end
        if (i_cmd.tev && expire) begin
            r_pidx  <= r_ridx;
            r_ppeer <= r_ordat.peer;
            r_pseq  <= r_ordat.seq;
        end
        if (push) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

@@ rtl/core/reliable_datagram_tracker.sv @@
// channel   dir  payload                                           handshake
// i_in      in   op, peer_addr, seq_num                            valid/ready
// o_out     out  event_res, out_peer, out_seq, slot, send_ack,     valid/ready
//                deliver, last
// i_cfg     in   index, data (0 retransmit, 1 reservation timeout) valid/ready
//
// send, data and ack items walk the outgoing or incoming table: one table read a cycle
// a tick walks the incoming table, then the outgoing table: the outgoing walk is read then update
// after reset a clearing pass over max(OUT_ENTRIES, IN_ENTRIES) entries runs before i_in.ready
// a stalled o_out holds the block in its result step; one result register decouples the sides
// config writes are always taken and land in registers
module reliable_datagram_tracker #(
    parameter int OUT_ENTRIES = rdt_pkg::OUT_ENTRIES_DEF,
    parameter int IN_ENTRIES  = rdt_pkg::IN_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdt_in_if.sink    i_in,
    rdt_out_if.source o_out,
    rdt_cfg_if.sink   i_cfg
);

    rdt_pkg::t_cmd cmd;
    rdt_pkg::t_sts sts;
    rdt_pkg::t_res res;
    logic          in_ready;
    logic          out_valid;

    // controller walks the tables, datapath holds tables, trackers and the result register
    rdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    rdt_dp #(
        .OUT_ENTRIES (OUT_ENTRIES),
        .IN_ENTRIES  (IN_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_op     (i_in.op),
        .i_in_peer   (i_in.peer_addr),
        .i_in_seq    (i_in.seq_num),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_res       (res)
    );

    // an item is taken only between operations
    assign i_in.ready = in_ready;
    // timeouts are plain registers, never busy
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = out_valid;
    assign o_out.event_res = res.ev;
    assign o_out.out_peer  = res.peer;
    assign o_out.out_seq   = res.seq;
    assign o_out.slot      = res.slot;
    assign o_out.send_ack  = res.ack;
    assign o_out.deliver   = res.dlv;
    assign o_out.last      = res.last;

endmodule

@@ dv/rdt_tb_pkg.sv @@
package rdt_tb_pkg;

    typedef struct {
        rdt_pkg::t_ev                ev;
        logic [rdt_pkg::PEER_W-1:0]  peer;
        logic [rdt_pkg::SEQ_W-1:0]   seq;
        logic [rdt_pkg::SLOT_W-1:0]  slot;
        logic                        ack;
        logic                        dlv;
        logic                        last;
    } t_event_rec;

    // mirror of both tables plus a queue of pending events
    class tracker_scoreboard;
        localparam int NO = rdt_pkg::OUT_ENTRIES_DEF;
        localparam int NI = rdt_pkg::IN_ENTRIES_DEF;

        logic [rdt_pkg::TMR_W-1:0]  retx_to;
        logic [rdt_pkg::TMR_W-1:0]  rsv_to;
        bit                         o_v[NO];
        logic [rdt_pkg::PEER_W-1:0] o_p[NO];
        logic [rdt_pkg::SEQ_W-1:0]  o_s[NO];
        logic [rdt_pkg::TMR_W-1:0]  o_t[NO];
        bit                         n_v[NI];
        logic [rdt_pkg::PEER_W-1:0] n_p[NI];
        logic [rdt_pkg::SEQ_W-1:0]  n_s[NI];
        logic [rdt_pkg::TMR_W-1:0]  n_t[NI];
        t_event_rec                 pending_events[$];
        int                         errors;
        int                         checked;
        int                         resends;

        function new();
            retx_to = rdt_pkg::RETX_RST;
            rsv_to  = rdt_pkg::RSV_RST;
            foreach (o_v[i]) o_v[i] = 0;
            foreach (n_v[i]) n_v[i] = 0;
            errors = 0;
            checked = 0;
            resends = 0;
        endfunction

        function void write_reg(logic [rdt_pkg::CFG_IDX_W-1:0] idx,
                                logic [rdt_pkg::TMR_W-1:0] val);
            if (idx == rdt_pkg::CFG_RETX) retx_to = val;
            else if (idx == rdt_pkg::CFG_RSV) rsv_to = val;
        endfunction

        function void push(rdt_pkg::t_ev ev, logic [rdt_pkg::PEER_W-1:0] p,
                           logic [rdt_pkg::SEQ_W-1:0] s, int sl,
                           bit ack, bit dlv, bit last);
            t_event_rec r;
            r.ev = ev; r.peer = p; r.seq = s; r.slot = sl[rdt_pkg::SLOT_W-1:0];
            r.ack = ack; r.dlv = dlv; r.last = last;
            pending_events.push_back(r);
        endfunction

        function void note_item(rdt_pkg::t_op op, logic [rdt_pkg::PEER_W-1:0] p,
                                logic [rdt_pkg::SEQ_W-1:0] s);
            int hit;
            int fr;
            int n;
            hit = -1;
            fr = -1;
            n = 0;
            case (op)
                rdt_pkg::OP_SEND, rdt_pkg::OP_ACK: begin
                    for (int i = 0; i < NO; i++)
                        if (hit < 0 && o_v[i] && o_p[i] == p && o_s[i] == s) hit = i;
                    for (int i = 0; i < NO; i++)
                        if (fr < 0 && !o_v[i]) fr = i;
                    if (op == rdt_pkg::OP_ACK) begin
                        if (hit >= 0) begin
                            o_v[hit] = 0;
                            push(rdt_pkg::EV_ACKED, p, s, hit, 0, 0, 1);
                        end else push(rdt_pkg::EV_UNK_ACK, p, s, 0, 0, 0, 1);
                    end else if (hit >= 0) begin
                        o_t[hit] = retx_to;
                        push(rdt_pkg::EV_REPLACED, p, s, hit, 0, 0, 1);
                    end else if (fr < 0) begin
                        push(rdt_pkg::EV_OUT_FULL, p, s, 0, 0, 0, 1);
                    end else begin
                        o_v[fr] = 1; o_p[fr] = p; o_s[fr] = s; o_t[fr] = retx_to;
                        push(rdt_pkg::EV_ADDED, p, s, fr, 0, 0, 1);
                    end
                end
                rdt_pkg::OP_DATA: begin
                    for (int i = 0; i < NI; i++)
                        if (hit < 0 && n_v[i] && n_p[i] == p && n_s[i] == s) hit = i;
                    for (int i = 0; i < NI; i++)
                        if (fr < 0 && !n_v[i]) fr = i;
                    // duplicates keep their original reservation timer
                    if (hit >= 0) push(rdt_pkg::EV_DUP, p, s, hit, 1, 0, 1);
                    else if (fr < 0) push(rdt_pkg::EV_NEW_NOREC, p, s, 0, 1, 1, 1);
                    else begin
                        n_v[fr] = 1; n_p[fr] = p; n_s[fr] = s; n_t[fr] = rsv_to;
                        push(rdt_pkg::EV_NEW, p, s, fr, 1, 1, 1);
                    end
                end
                default: begin
                    for (int i = 0; i < NI; i++) if (n_v[i]) begin
                        if (n_t[i] > 0) n_t[i]--;
                        if (n_t[i] == 0) n_v[i] = 0;
                    end
                    for (int i = 0; i < NO; i++) if (o_v[i]) begin
                        if (o_t[i] > 0) o_t[i]--;
                        if (o_t[i] == 0) begin
                            o_t[i] = retx_to;
                            push(rdt_pkg::EV_RESEND, o_p[i], o_s[i], i, 0, 0, 0);
                            n++;
                        end
                    end
                    if (n == 0) push(rdt_pkg::EV_IDLE_TICK, '0, '0, 0, 0, 0, 1);
                    else pending_events[$].last = 1;
                    resends += n;
                end
            endcase
        endfunction

        function void check_event(t_event_rec got);
            t_event_rec w;
            checked++;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result ev=%0d peer=%h seq=%h", $time, got.ev,
                         got.peer, got.seq);
                errors++;
                return;
            end
            w = pending_events.pop_front();
            if (got.ev !== w.ev || got.peer !== w.peer || got.seq !== w.seq ||
                got.slot !== w.slot || got.ack !== w.ack || got.dlv !== w.dlv ||
                got.last !== w.last) begin
                $display("%0t: mismatch expected ev=%0d peer=%h seq=%h slot=%0d %s%b%s%b%s%b",
                         $time, w.ev, w.peer, w.seq, w.slot, "ack=", w.ack, " dlv=", w.dlv,
                         " last=", w.last);
                $display("%0t:          actual   ev=%0d peer=%h seq=%h slot=%0d %s%b%s%b%s%b",
                         $time, got.ev, got.peer, got.seq, got.slot, "ack=", got.ack,
                         " dlv=", got.dlv, " last=", got.last);
                errors++;
            end
        endfunction
    endclass
endpackage

@@ dv/rdt_tb_ifs.sv @@
// the block's channel interfaces come with the rtl; nothing extra is needed here
package rdt_tb_ifs_pkg;
    localparam int WATCHDOG_CYCLES = 20000;
endpackage

@@ dv/reliable_datagram_tracker_tb.sv @@
module reliable_datagram_tracker_tb;

    logic i_clk;
    logic i_rst_n;

    rdt_in_if  in_ch();
    rdt_out_if out_ch();
    rdt_cfg_if cfg_ch();

    reliable_datagram_tracker dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    rdt_tb_pkg::tracker_scoreboard sb;
    int  idle_cycles;
    bit  timed_out;
    bit  sink_quiet;
    int  items_sent;

    // small pools of peers and sequence numbers so keys collide often
    logic [rdt_pkg::PEER_W-1:0] peer_pool[4];
    logic [rdt_pkg::SEQ_W-1:0]  seq_pool[4];

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > rdt_tb_ifs_pkg::WATCHDOG_CYCLES && !timed_out) begin
            timed_out <= 1;
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls, checks each accepted item
    initial begin
        int gap;
        rdt_tb_pkg::t_event_rec r;
        out_ch.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = sink_quiet ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk iff out_ch.valid);
            r.ev = rdt_pkg::t_ev'(out_ch.event_res);
            r.peer = out_ch.out_peer; r.seq = out_ch.out_seq;
            r.slot = out_ch.slot; r.ack = out_ch.send_ack; r.dlv = out_ch.deliver;
            r.last = out_ch.last;
            sb.check_event(r);
        end
    end

    task automatic write_cfg(logic [rdt_pkg::CFG_IDX_W-1:0] idx,
                             logic [rdt_pkg::TMR_W-1:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk iff cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_item(rdt_pkg::t_op op, logic [rdt_pkg::PEER_W-1:0] p,
                             logic [rdt_pkg::SEQ_W-1:0] s, bit pace);
        if (pace) repeat ($urandom_range(0, 17)) @(posedge i_clk);
        in_ch.valid     <= 1;
        in_ch.op        <= op;
        in_ch.peer_addr <= p;
        in_ch.seq_num   <= s;
        @(posedge i_clk iff in_ch.ready);
        sb.note_item(op, p, s);
        items_sent++;
        in_ch.valid <= 0;
        // the block is busy after taking an item anyway
        @(posedge i_clk);
    endtask

    // wait until every expected result is in, then let the clock run on with no new items
    task automatic drain();
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic random_item();
        int  k;
        logic [rdt_pkg::PEER_W-1:0] p;
        logic [rdt_pkg::SEQ_W-1:0]  s;
        k = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) begin
            p = rdt_pkg::PEER_W'({$urandom, $urandom});
            s = $urandom;
        end else begin
            p = peer_pool[$urandom_range(0, 3)];
            s = seq_pool[$urandom_range(0, 3)];
        end
        if (k < 3) send_item(rdt_pkg::OP_SEND, p, s, 1);
        else if (k < 5) send_item(rdt_pkg::OP_DATA, p, s, 1);
        else if (k < 7) send_item(rdt_pkg::OP_ACK, p, s, 1);
        else send_item(rdt_pkg::OP_TICK, rdt_pkg::PEER_W'({$urandom, $urandom}), $urandom, 1);
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        timed_out = 0;
        sink_quiet = 0;
        items_sent = 0;
        i_rst_n = 0;
        in_ch.valid = 0; in_ch.op = rdt_pkg::OP_TICK;
        in_ch.peer_addr = '0; in_ch.seq_num = '0;
        cfg_ch.valid = 0; cfg_ch.index = rdt_pkg::CFG_RETX; cfg_ch.data = '0;
        peer_pool = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hC0A8_0001_1F90, 48'h5555_AAAA_0F0F};
        seq_pool  = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: short timers so resends and expiry show up quickly
        write_cfg(rdt_pkg::CFG_RETX, 20'd2);
        write_cfg(rdt_pkg::CFG_RSV, 20'd1);
        send_item(rdt_pkg::OP_TICK, '0, '0, 0);                  // idle tick, empty tables
        send_item(rdt_pkg::OP_SEND, 48'h0, 32'h0, 0);
        send_item(rdt_pkg::OP_SEND, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(rdt_pkg::OP_SEND, 48'h0, 32'h0, 0);            // same key replaces
        send_item(rdt_pkg::OP_DATA, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(rdt_pkg::OP_DATA, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0); // duplicate
        send_item(rdt_pkg::OP_ACK, 48'h1234_5678_9ABC, 32'h1, 0);          // unknown ack
        send_item(rdt_pkg::OP_TICK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0); // frees reservation
        send_item(rdt_pkg::OP_TICK, '0, '0, 0);                  // both outgoing resend
        send_item(rdt_pkg::OP_DATA, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0); // new after expiry
        send_item(rdt_pkg::OP_ACK, 48'h0, 32'h0, 0);
        send_item(rdt_pkg::OP_ACK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        // fill the outgoing table past full
        for (int i = 0; i < 17; i++) send_item(rdt_pkg::OP_SEND, 48'hA0 + i, i, 0);
        drain();
        write_cfg(rdt_pkg::CFG_RETX, 20'd0);                     // zero behaves as one
        write_cfg(rdt_pkg::CFG_RSV, 20'hFFFFF);
        send_item(rdt_pkg::OP_TICK, '0, '0, 0);                  // idle tick: all sixteen count down, none resends yet
        // fill incoming table past full
        for (int i = 0; i < 33; i++) send_item(rdt_pkg::OP_DATA, 48'hB0 + i, ~i, 0);
        for (int i = 0; i < 16; i++) send_item(rdt_pkg::OP_ACK, 48'hA0 + i, i, 0);
        drain();

        // random phases with several timeout settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_cfg(rdt_pkg::CFG_RETX, 20'd3);
                    write_cfg(rdt_pkg::CFG_RSV, 20'd5);
                end
                1: begin
                    write_cfg(rdt_pkg::CFG_RETX, 20'd1);
                    write_cfg(rdt_pkg::CFG_RSV, 20'd2);
                end
                2: begin
                    write_cfg(rdt_pkg::CFG_RETX, 20'hFFFFF);
                    write_cfg(rdt_pkg::CFG_RSV, 20'd1);
                end
                default: begin
                    write_cfg(rdt_pkg::CFG_RETX, rdt_pkg::TMR_W'($urandom_range(1, 6)));
                    write_cfg(rdt_pkg::CFG_RSV, rdt_pkg::TMR_W'($urandom_range(1, 8)));
                end
            endcase
            sink_quiet = (ph == 1);
            for (int n = 0; n < 13; n++) begin
                random_item();
                // sender holds off until the block has emptied
                if (n == 6) while (sb.pending_events.size() != 0) @(posedge i_clk);
            end
            drain();
        end

        $display("sent %0d items, checked %0d results including %0d resends", items_sent,
                 sb.checked, sb.resends);
        if (sb.errors == 0 && sb.pending_events.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

@@ reliable_datagram_tracker.f @@
+incdir+rtl/core
rtl/core/rdt_pkg.sv
rtl/core/rdt_in_if.sv
rtl/core/rdt_out_if.sv
rtl/core/rdt_cfg_if.sv
rtl/core/rdt_ctrl.sv
rtl/core/rdt_dp.sv
rtl/core/reliable_datagram_tracker.sv
dv/rdt_tb_pkg.sv
dv/rdt_tb_ifs.sv
dv/reliable_datagram_tracker_tb.sv
